// File: hw/rtl/pits_pkg.sv
// shared constants, types and arctangent table of the tube sector test
package pits_pkg;

   localparam int COORD_WIDTH   = 32;
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;

   localparam int ACC_W        = 32;
   localparam int XW           = COORD_WIDTH + 3;
   localparam int ATAN_ENTRIES = 24;
   localparam int IDX_W        = 5;
   localparam int REQ_W        = ((3 * COORD_WIDTH + 7) / 8) * 8;
   localparam int RSP_W        = 8;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = COORD_WIDTH;
   localparam int NSTAGE       = CORDIC_STAGES + 2;
   localparam int RAD_JOIN     = 3;

   localparam logic [ACC_W-1:0] HALF_TURN  = ACC_W'(1) << (ACC_W - 1);
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INNER_RADIUS  = 3'd0,
      CSR_OUTER_RADIUS  = 3'd1,
      CSR_TUBE_LENGTH   = 3'd2,
      CSR_SECTOR_ENABLE = 3'd3,
      CSR_SECTOR_START  = 3'd4,
      CSR_SECTOR_SPAN   = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [COORD_WIDTH-2:0]      inner_radius;
      logic [COORD_WIDTH-2:0]      outer_radius;
      logic [COORD_WIDTH-1:0]      tube_length;
      logic                        sector_enable;
      logic signed [ANGLE_BITS:0]  sector_start;
      logic [ANGLE_BITS:0]         sector_span;
   } cfg_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic [ACC_W-1:0]     acc;
      logic                 origin;
      logic                 z_ok;
      logic                 rad_ok;
   } cordic_type;

   function automatic logic [ACC_W-1:0] atan_turn(input logic [IDX_W-1:0] idx);
      logic [ACC_W-1:0] val;
      case (idx)
         5'd0:    val = 32'h2000_0000;
         5'd1:    val = 32'h12E4_051E;
         5'd2:    val = 32'h09FB_385B;
         5'd3:    val = 32'h0511_11D4;
         5'd4:    val = 32'h028B_0D43;
         5'd5:    val = 32'h0145_D7E1;
         5'd6:    val = 32'h00A2_F61E;
         5'd7:    val = 32'h0051_7C55;
         5'd8:    val = 32'h0028_BE53;
         5'd9:    val = 32'h0014_5F2F;
         5'd10:   val = 32'h000A_2F98;
         5'd11:   val = 32'h0005_17CC;
         5'd12:   val = 32'h0002_8BE6;
         5'd13:   val = 32'h0001_45F3;
         5'd14:   val = 32'h0000_A2FA;
         5'd15:   val = 32'h0000_517D;
         5'd16:   val = 32'h0000_28BE;
         5'd17:   val = 32'h0000_145F;
         5'd18:   val = 32'h0000_0A30;
         5'd19:   val = 32'h0000_0518;
         5'd20:   val = 32'h0000_028C;
         5'd21:   val = 32'h0000_0146;
         5'd22:   val = 32'h0000_00A3;
         5'd23:   val = 32'h0000_0051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: hw/rtl/point_in_tube_sector.sv
// top level of the tube sector point test
// req channel: one point per beat, tdata = point_x, point_y, point_z (32 bits
// each, signed Q16.16, x in the low bits). rsp channel: one beat per point,
// tdata bit 0 = inside_res, upper bits zero. csr channel: register index and
// write data; index 0 inner radius, 1 outer radius, 2 tube length, 3 sector
// enable, 4 sector start, 5 sector span; other indexes are dropped. Write the
// registers only while no point is in flight.
// the path from req beat to rsp beat has one input stage, one stage
// per CORDIC rotation (16) and one decision stage that is also the output
// register. The squared-radius test runs beside the first CORDIC stages.
// throughput is one point per cycle while the receiver takes beats; every stage holds a valid bit and loads
// whenever it is empty or its successor moves, so bubbles close up.
// when the receiver stalls, beats pile up stage by stage and req_tready drops
// only once every stage holds a point; nothing is lost or repeated.
// reset clears all stage valid bits and the configuration registers to zero.
module point_in_tube_sector
   import pits_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // point_x, point_y, point_z
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // inside_res, zero fill
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type                cfg_ff, cfg_in;
   logic [NSTAGE-1:0]      valid_ff, valid_in;
   logic [NSTAGE:0]        ready;
   cordic_type             front_q;
   logic [COORD_WIDTH-1:0] mx, my;
   logic                   rad_ok, in_tube;
   cordic_type             cstage_d [CORDIC_STAGES];
   cordic_type             cstage_q [CORDIC_STAGES];

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            CSR_INNER_RADIUS:  cfg_in.inner_radius  = csr_data[COORD_WIDTH-2:0];
            CSR_OUTER_RADIUS:  cfg_in.outer_radius  = csr_data[COORD_WIDTH-2:0];
            CSR_TUBE_LENGTH:   cfg_in.tube_length   = csr_data[COORD_WIDTH-1:0];
            CSR_SECTOR_ENABLE: cfg_in.sector_enable = csr_data[0];
            CSR_SECTOR_START:  cfg_in.sector_start  = csr_data[ANGLE_BITS:0];
            CSR_SECTOR_SPAN:   cfg_in.sector_span   = csr_data[ANGLE_BITS:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stage valid bits and ready chain
   assign ready[NSTAGE] = rsp_tready;

   genvar g;
   generate
      for (g = 0; g < NSTAGE; g++) begin : g_ready
         assign ready[g] = !valid_ff[g] || ready[g+1];
      end
   endgenerate

   assign valid_in = {valid_ff[NSTAGE-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NSTAGE; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[NSTAGE-1];
   assign rsp_tdata  = {(RSP_W-1)'(0), in_tube};

   // datapath
   pits_front u_front (
      .clock    (clock),
      .en       (ready[0]),
      .req_data (req_tdata),
      .cfg      (cfg_ff),
      .stage_q  (front_q),
      .mx_q     (mx),
      .my_q     (my)
   );

   pits_radial u_radial (
      .clock  (clock),
      .en     (ready[3:1]),
      .mx     (mx),
      .my     (my),
      .cfg    (cfg_ff),
      .rad_ok (rad_ok)
   );

   generate
      for (g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
         if (g == 0) begin : g_first
            assign cstage_d[g] = front_q;
         end else if (g == RAD_JOIN) begin : g_join
            always_comb begin
               cstage_d[g]        = cstage_q[g-1];
               cstage_d[g].rad_ok = rad_ok;
            end
         end else begin : g_mid
            assign cstage_d[g] = cstage_q[g-1];
         end

         pits_cordic_stage u_stage (
            .clock     (clock),
            .en        (ready[g+1]),
            .stage_idx (IDX_W'(g)),
            .d         (cstage_d[g]),
            .q         (cstage_q[g])
         );
      end
   endgenerate

   pits_sector u_sector (
      .clock   (clock),
      .en      (ready[NSTAGE-1]),
      .cfg     (cfg_ff),
      .d       (cstage_q[CORDIC_STAGES-1]),
      .in_tube (in_tube)
   );

   // checks
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while every stage is full and output stalled");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted beat did not reach the input stage");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (valid_ff[0] && valid_ff[NSTAGE-1] && !rsp_tready))
      else $error("input stalled without a full stage and a stalled output");

endmodule

// File: hw/rtl/pits_front.sv
// input stage: unpack, half-turn pre-rotation, magnitudes and z range test
module pits_front
   import pits_pkg::*;
(
   input  logic                   clock,
   input  logic                   en,
   input  logic [REQ_W-1:0]       req_data,
   input  cfg_type                cfg,
   output cordic_type             stage_q,
   output logic [COORD_WIDTH-1:0] mx_q,
   output logic [COORD_WIDTH-1:0] my_q
);

   logic [COORD_WIDTH-1:0] xu, yu, zu, zm;
   logic signed [XW-1:0]   xe, ye;
   logic                   neg;
   cordic_type             stage_in, stage_ff;
   logic [COORD_WIDTH-1:0] mx_in, my_in, mx_ff, my_ff;

   assign xu = req_data[COORD_WIDTH-1:0];
   assign yu = req_data[2*COORD_WIDTH-1:COORD_WIDTH];
   assign zu = req_data[3*COORD_WIDTH-1:2*COORD_WIDTH];

   always_comb begin
      xe  = {{(XW-COORD_WIDTH){xu[COORD_WIDTH-1]}}, xu};
      ye  = {{(XW-COORD_WIDTH){yu[COORD_WIDTH-1]}}, yu};
      neg = xu[COORD_WIDTH-1];
      stage_in.x      = neg ? -xe : xe;
      stage_in.y      = neg ? -ye : ye;
      stage_in.acc    = neg ? HALF_TURN : '0;
      stage_in.origin = (xu == '0) && (yu == '0);
      mx_in = xu[COORD_WIDTH-1] ? (~xu + COORD_WIDTH'(1)) : xu;
      my_in = yu[COORD_WIDTH-1] ? (~yu + COORD_WIDTH'(1)) : yu;
      zm    = zu[COORD_WIDTH-1] ? (~zu + COORD_WIDTH'(1)) : zu;
      stage_in.z_ok   = !({zm, 1'b0} > {1'b0, cfg.tube_length});
      stage_in.rad_ok = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
         mx_ff    <= mx_in;
         my_ff    <= my_in;
      end
   end

   assign stage_q = stage_ff;
   assign mx_q    = mx_ff;
   assign my_q    = my_ff;

endmodule

// File: hw/rtl/pits_radial.sv
// radius window test on squared values, three stages: square, sum, compare
module pits_radial
   import pits_pkg::*;
(
   input  logic                   clock,
   input  logic [2:0]             en,
   input  logic [COORD_WIDTH-1:0] mx,
   input  logic [COORD_WIDTH-1:0] my,
   input  cfg_type                cfg,
   output logic                   rad_ok
);

   logic [2*COORD_WIDTH-1:0] sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [2*COORD_WIDTH-3:0] sqi_in, sqo_in, sqi_ff, sqo_ff, ri2_ff, ro2_ff;
   logic [2*COORD_WIDTH:0]   r2_in, r2_ff;
   logic                     rad_ok_in, rad_ok_ff;

   assign sqx_in = mx * mx;
   assign sqy_in = my * my;
   assign sqi_in = cfg.inner_radius * cfg.inner_radius;
   assign sqo_in = cfg.outer_radius * cfg.outer_radius;
   assign r2_in  = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign rad_ok_in = !(r2_ff < (2*COORD_WIDTH+1)'(ri2_ff))
                   && !((2*COORD_WIDTH+1)'(ro2_ff) < r2_ff);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         sqi_ff <= sqi_in;
         sqo_ff <= sqo_in;
      end
      if (en[1]) begin
         r2_ff  <= r2_in;
         ri2_ff <= sqi_ff;
         ro2_ff <= sqo_ff;
      end
      if (en[2]) begin
         rad_ok_ff <= rad_ok_in;
      end
   end

   assign rad_ok = rad_ok_ff;

endmodule

// File: hw/rtl/pits_cordic_stage.sv
// one vectoring micro-rotation with its angle update
module pits_cordic_stage
   import pits_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [IDX_W-1:0] stage_idx,
   input  cordic_type       d,
   output cordic_type       q
);

   logic signed [XW-1:0] xs, ys, dx, dy;
   logic [ACC_W-1:0]     ang;
   logic                 pos;
   cordic_type           q_in, q_ff;

   always_comb begin
      xs  = d.x;
      ys  = d.y;
      dx  = ys >>> stage_idx;
      dy  = xs >>> stage_idx;
      ang = atan_turn(stage_idx);
      pos = !ys[XW-1] && (ys != '0);
      q_in = d;
      if (pos) begin
         q_in.x   = xs + dx;
         q_in.y   = ys - dy;
         q_in.acc = d.acc + ang;
      end else begin
         q_in.x   = xs - dx;
         q_in.y   = ys + dy;
         q_in.acc = d.acc - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

// File: hw/rtl/pits_sector.sv
// azimuth rounding, sector window and final decision register
module pits_sector
   import pits_pkg::*;
(
   input  logic       clock,
   input  logic       en,
   input  cfg_type    cfg,
   input  cordic_type d,
   output logic       in_tube
);

   localparam logic signed [ANGLE_BITS+2:0] FULL_TURN = (ANGLE_BITS+3)'(1) << ANGLE_BITS;

   logic [ACC_W-1:0]               acc_r;
   logic [ANGLE_BITS-1:0]          phi;
   logic signed [ANGLE_BITS+2:0]   phi_s, start_s, span_s, end_s, wrap_s;
   logic                           sec_ok, inside_in, inside_ff;

   always_comb begin
      acc_r   = d.acc + ROUND_HALF;
      phi     = d.origin ? '0 : acc_r[ACC_W-1 -: ANGLE_BITS];
      phi_s   = {3'b000, phi};
      start_s = {{2{cfg.sector_start[ANGLE_BITS]}}, cfg.sector_start};
      span_s  = {2'b00, cfg.sector_span};
      end_s   = start_s + span_s;
      wrap_s  = start_s + FULL_TURN;
      if (!start_s[ANGLE_BITS+2]) begin
         sec_ok = !((phi_s < start_s) || (phi_s > end_s));
      end else begin
         sec_ok = !((phi_s < wrap_s) && (phi_s > end_s));
      end
      inside_in = d.z_ok && d.rad_ok && (!cfg.sector_enable || sec_ok);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         inside_ff <= inside_in;
      end
   end

   assign in_tube = inside_ff;

endmodule

// File: verif/testbench.sv
// testbench of the tube sector point test: directed and random points checked beat by beat
module testbench
   import pits_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int UNIT = 65536;
   localparam int LONG_HOLD = 150;
   localparam logic [31:0] MAX31 = 32'h7FFF_FFFF;
   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
   localparam logic [31:0] COORD_MIN = 32'h8000_0000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam longint FULL_TURN = 64'd1 << ANGLE_BITS;
   localparam real TWO_PI = 2.0 * 3.14159265358979323846;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata;   // point_x, point_y, point_z
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // inside_res, zero fill
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   cfg_type tube_cfg;
   logic inside_expected[$];
   logic inside_want;
   int mismatch_count = 0;
   bit idling = 1'b1;
   bit hold_request = 1'b0;

   point_in_tube_sector DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] atan_step(int stage);
      return 32'($rtoi($atan(2.0 ** (-stage)) / TWO_PI * 4294967296.0 + 0.5));
   endfunction

   // vectoring rotation, angle accumulated in 2^-32 turn
   function automatic logic [ANGLE_BITS-1:0] azimuth_turns(longint ax, longint ay);
      logic [ACC_W-1:0] acc;
      longint dx, dy;
      acc = '0;
      if (ax == 0 && ay == 0) return '0;
      if (ax < 0) begin
         ax = -ax;
         ay = -ay;
         acc = HALF_TURN;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         dx = ay >>> i;
         dy = ax >>> i;
         if (ay > 0) begin
            ax += dx;
            ay -= dy;
            acc += atan_step(i);
         end else begin
            ax -= dx;
            ay += dy;
            acc -= atan_step(i);
         end
      end
      acc += ROUND_HALF;
      return acc[ACC_W-1 -: ANGLE_BITS];
   endfunction

   function automatic logic tube_contains(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      longint sx, sy, sz, phi, lo, hi;
      logic [63:0] mx, my, mz;
      logic [65:0] rr, inner_sq, outer_sq;
      logic [33:0] z2;
      logic signed [ANGLE_BITS:0] s_start;
      logic ok;
      sx = longint'(signed'(px));
      sy = longint'(signed'(py));
      sz = longint'(signed'(pz));
      mx = (sx < 0) ? -sx : sx;
      my = (sy < 0) ? -sy : sy;
      mz = (sz < 0) ? -sz : sz;
      rr = mx * mx + my * my;
      inner_sq = tube_cfg.inner_radius * tube_cfg.inner_radius;
      outer_sq = tube_cfg.outer_radius * tube_cfg.outer_radius;
      z2 = 34'(mz) << 1;
      ok = !(rr < inner_sq || outer_sq < rr || z2 > tube_cfg.tube_length);
      if (ok && tube_cfg.sector_enable) begin
         phi = azimuth_turns(sx, sy);
         s_start = tube_cfg.sector_start;
         lo = s_start;
         hi = lo + longint'(tube_cfg.sector_span);
         if (lo >= 0) ok = !(phi < lo || phi > hi);
         else ok = !(phi < lo + FULL_TURN && phi > hi);
      end
      return ok;
   endfunction

   function automatic logic [31:0] to_coord(real v);
      if (v >= 2147483647.0) return MAX31;
      if (v <= -2147483648.0) return COORD_MIN;
      return 32'($rtoi(v));
   endfunction

   task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      int gap;
      gap = idling ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pz, py, px};
      do @(posedge clock); while (!req_tready);
      inside_expected.push_back(tube_contains(px, py, pz));
   endtask

   task automatic wait_pipeline_empty();
      req_tvalid <= 1'b0;
      while (inside_expected.size() != 0) @(posedge clock);
      repeat (NSTAGE + 4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_INNER_RADIUS:  tube_cfg.inner_radius = value[COORD_WIDTH-2:0];
         CSR_OUTER_RADIUS:  tube_cfg.outer_radius = value[COORD_WIDTH-2:0];
         CSR_TUBE_LENGTH:   tube_cfg.tube_length = value;
         CSR_SECTOR_ENABLE: tube_cfg.sector_enable = value[0];
         CSR_SECTOR_START:  tube_cfg.sector_start = value[ANGLE_BITS:0];
         CSR_SECTOR_SPAN:   tube_cfg.sector_span = value[ANGLE_BITS:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_tube(logic [31:0] inner_r, logic [31:0] outer_r, logic [31:0] length,
                           logic [31:0] enable, logic [31:0] start, logic [31:0] span);
      wait_pipeline_empty();
      write_reg(CSR_INNER_RADIUS, inner_r);
      write_reg(CSR_OUTER_RADIUS, outer_r);
      write_reg(CSR_TUBE_LENGTH, length);
      write_reg(CSR_SECTOR_ENABLE, enable);
      write_reg(CSR_SECTOR_START, start);
      write_reg(CSR_SECTOR_SPAN, span);
   endtask

   task automatic random_tube();
      logic [31:0] top, outer_r, inner_r, length, start, span;
      int pick;
      top = 32'd1 << $urandom_range(1, 31);
      outer_r = $urandom_range(top - 1, top >> 1);
      pick = $urandom_range(0, 19);
      if (pick < 3) inner_r = '0;
      else if (pick < 5) inner_r = $urandom_range(MAX31, outer_r);
      else inner_r = to_coord(real'(outer_r) * $urandom_range(0, 100) / 100.0);
      pick = $urandom_range(0, 9);
      if (pick == 0) length = '0;
      else if (pick == 1) length = MAX32;
      else length = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(0, 4) == 0) start = $urandom;
      else start = $urandom_range(0, 131070) - 65535;
      pick = $urandom_range(0, 9);
      if (pick == 0) span = '0;
      else if (pick == 1) span = 32'(FULL_TURN);
      else if (pick == 2) span = $urandom_range(131071, 65537);
      else span = $urandom_range(0, 65536);
      set_tube(inner_r, outer_r, length, 32'($urandom_range(0, 9) < 7), start, span);
   endtask

   // mostly points across the shell with a margin past its radii and end caps, the rest raw noise
   task automatic send_random_point();
      real rho, theta, u;
      if ($urandom_range(0, 4) == 0) begin
         send_point($urandom, $urandom, $urandom);
      end else begin
         u = $urandom_range(0, 10000) / 10000.0;
         rho = real'(tube_cfg.inner_radius) * 0.9
               + u * (real'(tube_cfg.outer_radius) * 1.1 - real'(tube_cfg.inner_radius) * 0.9);
         theta = real'($urandom) / 4294967296.0 * TWO_PI;
         u = $urandom_range(0, 10000) / 10000.0;
         send_point(to_coord(rho * $cos(theta)), to_coord(rho * $sin(theta)),
                    to_coord((u - 0.5) * 1.2 * real'(tube_cfg.tube_length)));
      end
   endtask

   task automatic test_reset_state();
      send_point(0, 0, 0);
      send_point(1, 0, 0);
      send_point(0, 0, 1);
   endtask

   task automatic test_tube_bounds();
      set_tube(UNIT, 3 * UNIT, 4 * UNIT, 0, 0, 0);
      send_point(UNIT, 0, 0);
      send_point(UNIT - 1, 0, 0);
      send_point(0, -3 * UNIT, 0);
      send_point(3 * UNIT + 1, 0, 0);
      send_point(0, 2 * UNIT, 2 * UNIT);
      send_point(0, 2 * UNIT, -2 * UNIT - 1);
      send_point(COORD_MIN, COORD_MIN, COORD_MIN);
      send_point(MAX31, MAX31, MAX31);
      set_tube(0, MAX31, MAX32, 0, 0, 0);
      send_point(MAX31, 0, MAX31);
      send_point(COORD_MIN, 0, 0);
      send_point(0, 0, COORD_MIN);
   endtask

   task automatic test_register_decode();
      wait_pipeline_empty();
      write_reg(CSR_SPARE_LO, MAX32);
      write_reg(CSR_SPARE_HI, MAX32);
      send_point(MAX31, 0, MAX31);
      send_point(0, 0, 0);
      // inner radius above outer radius
      set_tube(4 * UNIT, 2 * UNIT, MAX32, 0, 0, 0);
      send_point(3 * UNIT, 0, 0);
   endtask

   task automatic test_sector_cases();
      set_tube(0, MAX31, MAX32, 1, 0, 16384);
      send_point(UNIT, 0, 0);
      send_point(0, UNIT, 0);
      send_point(-UNIT, 0, 0);
      send_point(UNIT, -UNIT, 0);
      send_point(0, 0, 0);
      set_tube(0, MAX31, MAX32, 1, -8192, 16384);
      send_point(UNIT, -UNIT, 0);
      send_point(0, -UNIT, 0);
      send_point(32'h4000_0000, -1, 0);
      set_tube(0, MAX31, MAX32, 1, 65535, 131071);
      send_point(32'h4000_0000, -1, 0);
      send_point(UNIT, -UNIT, 0);
      set_tube(0, MAX31, MAX32, 1, 32'h0001_0000, 0);
      send_point(-UNIT, 0, 0);
   endtask

   task automatic test_backpressure();
      random_tube();
      idling = 1'b0;
      hold_request = 1'b1;
      repeat (45) send_random_point();
      wait_pipeline_empty();
      idling = 1'b1;
   endtask

   task automatic test_random_tubes();
      for (int phase = 0; phase < 10; phase++) begin
         random_tube();
         idling = ($urandom_range(0, 3) != 0);
         repeat (50) send_random_point();
      end
      idling = 1'b1;
   endtask

   initial begin : receiver
      int n;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            n = LONG_HOLD;
         end else if (idling && $urandom_range(0, 3) == 0) begin
            n = pick_gap();
         end else begin
            n = 0;
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (inside_expected.size() == 0) begin
            $error("inside_res: no beat expected, actual %0d", rsp_tdata[0]);
            mismatch_count++;
         end else begin
            inside_want = inside_expected.pop_front();
            if (rsp_tdata[0] !== inside_want) begin
               $error("inside_res: expected %0d, actual %0d", inside_want, rsp_tdata[0]);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      tube_cfg = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_tube_bounds();
      test_register_decode();
      test_sector_cases();
      test_backpressure();
      test_random_tubes();
      wait_pipeline_empty();
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(20_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule
